@@ design/two_plane_pixel_plotter_defines.svh @@
// Assertion macros for the pixel plotter checker.
`ifndef TWO_PLANE_PIXEL_PLOTTER_DEFINES_SVH
`define TWO_PLANE_PIXEL_PLOTTER_DEFINES_SVH

// Overlapping implication, disabled while reset is asserted.
`define TPP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication, disabled while reset is asserted.
`define TPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpp_pkg.sv @@
package tpp_pkg;

    localparam int CFG_DIM_W = 11;
    localparam int ROT_W     = 2;
    localparam int MAP_W     = 12;
    localparam int POS_W     = 12;
    localparam int CODE_W    = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [2:0] REG_PANEL_WIDTH    = 3'd0;
    localparam logic [2:0] REG_PANEL_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_ROTATION       = 3'd2;
    localparam logic [2:0] REG_BLACK_INVERTED = 3'd3;
    localparam logic [2:0] REG_COLOR_INVERTED = 3'd4;
    localparam logic [2:0] REG_LAYER_MAP      = 3'd5;

    localparam logic [ROT_W-1:0] ROT_0 = 2'd0;
    localparam logic [ROT_W-1:0] ROT_1 = 2'd1;
    localparam logic [ROT_W-1:0] ROT_2 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_3 = 2'd3;

    localparam logic [CODE_W-1:0] COLOR_0 = 3'd0;
    localparam logic [CODE_W-1:0] COLOR_1 = 3'd1;
    localparam logic [CODE_W-1:0] COLOR_2 = 3'd2;
    localparam logic [CODE_W-1:0] COLOR_3 = 3'd3;
    localparam logic [CODE_W-1:0] COLOR_4 = 3'd4;
    localparam logic [CODE_W-1:0] COLOR_5 = 3'd5;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] panel_width;
        logic [CFG_DIM_W-1:0] panel_height;
        logic [ROT_W-1:0]     rotation;
        logic                 black_inverted;
        logic                 color_inverted;
        logic [MAP_W-1:0]     layer_map;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_ADDR,
        ST_READ,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic rot;
        logic mul;
        logic addr;
        logic rmw;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_status;

endpackage

@@ design/tpp_ram.sv @@
module tpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tpp_regs.sv @@
module tpp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpp_pkg::APB_AW-1:0]  paddr,
    input  logic [tpp_pkg::APB_DW-1:0]  pwdata,
    output logic [tpp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output tpp_pkg::t_cfg               o_cfg
);
    import tpp_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_index;
    logic       w_wr;

    assign w_index = paddr[APB_AW-1:2];
    assign w_wr    = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_index)
                REG_PANEL_WIDTH:    n_cfg.panel_width    = pwdata[CFG_DIM_W-1:0];
                REG_PANEL_HEIGHT:   n_cfg.panel_height   = pwdata[CFG_DIM_W-1:0];
                REG_ROTATION:       n_cfg.rotation       = pwdata[ROT_W-1:0];
                REG_BLACK_INVERTED: n_cfg.black_inverted = pwdata[0];
                REG_COLOR_INVERTED: n_cfg.color_inverted = pwdata[0];
                REG_LAYER_MAP:      n_cfg.layer_map      = pwdata[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.panel_width    <= 11'd200;
            r_cfg.panel_height   <= 11'd200;
            r_cfg.rotation       <= ROT_0;
            r_cfg.black_inverted <= 1'b1;
            r_cfg.color_inverted <= 1'b0;
            r_cfg.layer_map      <= 12'd420;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_index)
            REG_PANEL_WIDTH:    prdata = APB_DW'(r_cfg.panel_width);
            REG_PANEL_HEIGHT:   prdata = APB_DW'(r_cfg.panel_height);
            REG_ROTATION:       prdata = APB_DW'(r_cfg.rotation);
            REG_BLACK_INVERTED: prdata = APB_DW'(r_cfg.black_inverted);
            REG_COLOR_INVERTED: prdata = APB_DW'(r_cfg.color_inverted);
            REG_LAYER_MAP:      prdata = APB_DW'(r_cfg.layer_map);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/tpp_ctrl.sv @@
module tpp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tpp_pkg::t_dp_status i_status,
    output tpp_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);
    import tpp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ROT;
                end
            end
            ST_ROT: begin
                o_cmd.rot = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADDR;
            end
            ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.rmw = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ design/tpp_dp.sv @@
module tpp_dp #(
    parameter int MAX_DIM     = 1024,
    parameter int PLANE_BYTES = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpp_pkg::t_dp_cmd                  i_cmd,
    output tpp_pkg::t_dp_status               o_status,
    input  tpp_pkg::t_cfg                     i_cfg,
    input  logic signed [tpp_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [tpp_pkg::POS_W-1:0]  i_pos_y,
    input  logic [tpp_pkg::CODE_W-1:0]        i_color_code,
    output logic                              o_done,
    output logic [$clog2(PLANE_BYTES)-1:0]    o_byte_addr,
    output logic [7:0]                        o_black_byte,
    output logic [7:0]                        o_color_byte,
    output logic                              o_written
);
    import tpp_pkg::*;

    localparam int AW = $clog2(PLANE_BYTES);
    localparam int DW = $clog2(MAX_DIM + 8);
    localparam int CW = ((DW > CFG_DIM_W) ? DW : CFG_DIM_W) + 2;
    localparam int MW = 2 * DW;
    localparam int PW = MW + 1;

    // input capture
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    logic [CODE_W-1:0]       r_code;

    // rotation stage
    logic signed [CW-1:0] w_raw, h_raw, w_s, h_s, hp_s, rw_s, rh_s;
    logic signed [CW-1:0] x_e, y_e, xd_s, yp_s;
    logic                 in_range;
    logic [1:0]           entry;

    logic          r_ok;
    logic [DW-1:0] r_xd;
    logic [DW-1:0] r_yp;
    logic [DW-1:0] r_hp;
    logic [2:0]    r_bitpos;
    logic          r_set_b;
    logic          r_set_c;

    // address stage
    logic [MW-1:0]   r_prod;
    logic [PW-1:0]   sum;
    logic [PW-4:0]   addr_full;
    logic            r_wr_ok;
    logic [AW-1:0]   r_addr;

    // plane access
    logic [AW-1:0] r_clr;
    logic [15:0]   rd_data;
    logic [7:0]    mask, new_b, new_c;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;

    logic          r_done;
    logic [AW-1:0] r_byte_addr;
    logic [7:0]    r_black_byte;
    logic [7:0]    r_color_byte;
    logic          r_written;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_code <= i_color_code;
        end
    end

    always_comb begin
        w_raw = CW'(i_cfg.panel_width);
        h_raw = CW'(i_cfg.panel_height);
        w_s   = (w_raw > CW'(MAX_DIM)) ? CW'(MAX_DIM) : w_raw;
        h_s   = (h_raw > CW'(MAX_DIM)) ? CW'(MAX_DIM) : h_raw;
        hp_s  = (h_s + CW'(7)) & ~CW'(7);
        rw_s  = i_cfg.rotation[0] ? h_s : w_s;
        rh_s  = i_cfg.rotation[0] ? w_s : h_s;
        x_e   = CW'(r_x);
        y_e   = CW'(r_y);
        in_range = !x_e[CW-1] && (x_e < rw_s) && !y_e[CW-1] && (y_e < rh_s) &&
                   (r_code <= COLOR_5);

        // distance from the right edge and row within the padded column
        unique case (i_cfg.rotation)
            ROT_0: begin
                xd_s = w_s - CW'(1) - x_e;
                yp_s = y_e;
            end
            ROT_1: begin
                xd_s = y_e;
                yp_s = x_e;
            end
            ROT_2: begin
                xd_s = x_e;
                yp_s = hp_s - CW'(1) - y_e;
            end
            ROT_3: begin
                xd_s = w_s - CW'(1) - y_e;
                yp_s = hp_s - CW'(1) - x_e;
            end
            default: begin
                xd_s = x_e;
                yp_s = y_e;
            end
        endcase

        unique case (r_code)
            COLOR_0: entry = i_cfg.layer_map[1:0];
            COLOR_1: entry = i_cfg.layer_map[3:2];
            COLOR_2: entry = i_cfg.layer_map[5:4];
            COLOR_3: entry = i_cfg.layer_map[7:6];
            COLOR_4: entry = i_cfg.layer_map[9:8];
            COLOR_5: entry = i_cfg.layer_map[11:10];
            default: entry = 2'b00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot) begin
            r_ok     <= in_range;
            r_xd     <= DW'(xd_s);
            r_yp     <= DW'(yp_s);
            r_hp     <= DW'(hp_s);
            r_bitpos <= ~yp_s[2:0];
            r_set_b  <= entry[0] ^ i_cfg.black_inverted;
            r_set_c  <= entry[1] ^ i_cfg.color_inverted;
        end
        if (i_cmd.mul) begin
            r_prod <= MW'(r_xd) * MW'(r_hp);
        end
        if (i_cmd.addr) begin
            r_wr_ok <= r_ok && (addr_full < PLANE_BYTES);
            r_addr  <= AW'(addr_full);
        end
    end

    assign sum       = PW'(r_prod) + PW'(r_yp);
    assign addr_full = sum[PW-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    assign o_status.clr_last = (r_clr == AW'(PLANE_BYTES - 1));

    // read-modify-write of both planes, color in the upper byte
    assign mask  = 8'd1 << r_bitpos;
    assign new_b = r_set_b ? (rd_data[7:0] | mask) : (rd_data[7:0] & ~mask);
    assign new_c = r_set_c ? (rd_data[15:8] | mask) : (rd_data[15:8] & ~mask);

    assign ram_we    = i_cmd.clr | (i_cmd.rmw & r_wr_ok);
    assign ram_waddr = i_cmd.clr ? r_clr : r_addr;
    assign ram_wdata = i_cmd.clr ? 16'd0 : {new_c, new_b};

    tpp_ram #(
        .WIDTH (16),
        .DEPTH (PLANE_BYTES)
    ) u_planes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.rmw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rmw) begin
            r_written    <= r_wr_ok;
            r_byte_addr  <= r_wr_ok ? r_addr : '0;
            r_black_byte <= r_wr_ok ? new_b : 8'd0;
            r_color_byte <= r_wr_ok ? new_c : 8'd0;
        end
    end

    assign o_done       = r_done;
    assign o_byte_addr  = r_byte_addr;
    assign o_black_byte = r_black_byte;
    assign o_color_byte = r_color_byte;
    assign o_written    = r_written;

endmodule

@@ design/two_plane_pixel_plotter.sv @@
// Channel     Handshake                          Fields
// config      psel/penable/pwrite, pready = 1    paddr, pwdata, prdata
// plot in     start & !busy                      i_pos_x, i_pos_y, i_color_code
// result out  o_done, one cycle                  o_byte_addr, o_black_byte,
//                                                o_color_byte, o_written
//
// A plot runs through five controller steps (rotate, multiply, address, plane
// read, plane write) and then the result strobe, which falls in the cycle busy
// drops, so a new start is taken alongside it.
// After reset both planes are zeroed, one byte address per cycle through all
// PLANE_BYTES addresses, with busy high; config writes are taken throughout.
// The receiver cannot stall: o_done marks each result for one cycle only.
module two_plane_pixel_plotter #(
    parameter int MAX_DIM     = 1024,
    parameter int PLANE_BYTES = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpp_pkg::APB_AW-1:0]        paddr,
    input  logic [tpp_pkg::APB_DW-1:0]        pwdata,
    output logic [tpp_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tpp_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [tpp_pkg::POS_W-1:0]  i_pos_y,
    input  logic [tpp_pkg::CODE_W-1:0]        i_color_code,
    output logic                              o_done,
    output logic [$clog2(PLANE_BYTES)-1:0]    o_byte_addr,
    output logic [7:0]                        o_black_byte,
    output logic [7:0]                        o_color_byte,
    output logic                              o_written
);
    import tpp_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    tpp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tpp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tpp_dp #(
        .MAX_DIM     (MAX_DIM),
        .PLANE_BYTES (PLANE_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg        (cfg),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_color_code (i_color_code),
        .o_done       (o_done),
        .o_byte_addr  (o_byte_addr),
        .o_black_byte (o_black_byte),
        .o_color_byte (o_color_byte),
        .o_written    (o_written)
    );

endmodule

@@ design/tpp_checker.sv @@
`include "two_plane_pixel_plotter_defines.svh"

module tpp_checker #(
    parameter int PLANE_BYTES = 16384
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_done,
    input logic [$clog2(PLANE_BYTES)-1:0] o_byte_addr,
    input logic [7:0]                     o_black_byte,
    input logic [7:0]                     o_color_byte,
    input logic                           o_written
);

    `TPP_ASSERT_IMPL(a_done_when_idle, i_clk, i_rst_n, o_done, !busy, "result while busy")
    `TPP_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `TPP_ASSERT_IMPL(a_accept_latency, i_clk, i_rst_n, start && !busy, ##6 o_done, "late result")
    `TPP_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result repeated")
    `TPP_ASSERT_IMPL(a_drop_zero, i_clk, i_rst_n, o_done && !o_written, o_byte_addr == '0 && o_black_byte == 8'd0 && o_color_byte == 8'd0, "dropped plot not zero")

endmodule

bind two_plane_pixel_plotter tpp_checker #(
    .PLANE_BYTES (PLANE_BYTES)
) u_tpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_byte_addr  (o_byte_addr),
    .o_black_byte (o_black_byte),
    .o_color_byte (o_color_byte),
    .o_written    (o_written)
);

@@ tb/tb_two_plane_pixel_plotter.sv @@
module tb_two_plane_pixel_plotter;
    import tpp_pkg::*;

    localparam int MAX_DIM        = 1024;
    localparam int PLANE_BYTES    = 16384;
    localparam int ADDR_W         = $clog2(PLANE_BYTES);
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 178;

    // register slots past the map, writes there are dropped
    localparam logic [2:0] REG_UNUSED_6 = 3'd6;
    localparam logic [2:0] REG_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_addr;
        logic [7:0]        black_byte;
        logic [7:0]        color_byte;
        logic              written;
    } plot_result_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       start;
    logic                       busy;
    logic signed [POS_W-1:0]    i_pos_x;
    logic signed [POS_W-1:0]    i_pos_y;
    logic [CODE_W-1:0]          i_color_code;
    logic                       o_done;
    logic [ADDR_W-1:0]          o_byte_addr;
    logic [7:0]                 o_black_byte;
    logic [7:0]                 o_color_byte;
    logic                       o_written;

    two_plane_pixel_plotter #(
        .MAX_DIM     (MAX_DIM),
        .PLANE_BYTES (PLANE_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_color_code (i_color_code),
        .o_done       (o_done),
        .o_byte_addr  (o_byte_addr),
        .o_black_byte (o_black_byte),
        .o_color_byte (o_color_byte),
        .o_written    (o_written)
    );

    // shadow copies of the block's registers and frame planes
    logic [CFG_DIM_W-1:0] cfg_panel_width;
    logic [CFG_DIM_W-1:0] cfg_panel_height;
    logic [ROT_W-1:0]     cfg_rotation;
    logic                 cfg_black_inv;
    logic                 cfg_color_inv;
    logic [MAP_W-1:0]     cfg_layer_map;
    logic [7:0]           black_img [0:PLANE_BYTES-1];
    logic [7:0]           color_img [0:PLANE_BYTES-1];

    plot_result_t plots_pending[$];
    int           fail_count;
    int           sender_idle_pct;
    int           idle_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int sat_dim(input int d);
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    function automatic int rotated_width();
        return cfg_rotation[0] ? sat_dim(int'(cfg_panel_height)) : sat_dim(int'(cfg_panel_width));
    endfunction

    function automatic int rotated_height();
        return cfg_rotation[0] ? sat_dim(int'(cfg_panel_width)) : sat_dim(int'(cfg_panel_height));
    endfunction

    // Applies one plot to the shadow planes and returns the result it produces.
    function automatic plot_result_t predict_plot(input int x, input int y, input int code);
        plot_result_t r;
        int           w;
        int           hp;
        int           rw;
        int           rh;
        int           t;
        int           addr;
        logic [1:0]   entry;
        logic [7:0]   bmask;
        r  = '0;
        w  = sat_dim(int'(cfg_panel_width));
        hp = (sat_dim(int'(cfg_panel_height)) + 7) & ~7;
        rw = rotated_width();
        rh = rotated_height();
        if (x < 0 || x >= rw || y < 0 || y >= rh || code > 5)
            return r;
        case (cfg_rotation)
            ROT_1: begin
                t = x;
                x = w - 1 - y;
                y = t;
            end
            ROT_2: begin
                x = w - 1 - x;
                y = hp - 1 - y;
            end
            ROT_3: begin
                t = x;
                x = y;
                y = hp - 1 - t;
            end
            default: ;
        endcase
        addr = ((w - 1 - x) * hp + y) / 8;
        if (addr >= PLANE_BYTES)
            return r;
        entry = 2'(cfg_layer_map >> (2 * code));
        bmask = 8'h80 >> (y % 8);
        if (entry[0] ^ cfg_black_inv)
            black_img[addr] = black_img[addr] | bmask;
        else
            black_img[addr] = black_img[addr] & ~bmask;
        if (entry[1] ^ cfg_color_inv)
            color_img[addr] = color_img[addr] | bmask;
        else
            color_img[addr] = color_img[addr] & ~bmask;
        r.byte_addr  = ADDR_W'(addr);
        r.black_byte = black_img[addr];
        r.color_byte = color_img[addr];
        r.written    = 1'b1;
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PANEL_WIDTH:    cfg_panel_width  = value[CFG_DIM_W-1:0];
            REG_PANEL_HEIGHT:   cfg_panel_height = value[CFG_DIM_W-1:0];
            REG_ROTATION:       cfg_rotation     = value[ROT_W-1:0];
            REG_BLACK_INVERTED: cfg_black_inv    = value[0];
            REG_COLOR_INVERTED: cfg_color_inv    = value[0];
            REG_LAYER_MAP:      cfg_layer_map    = value[MAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // start stays high after a transaction, unless a random idle gap is drawn, so back-to-back plots need no gap
    task automatic send_plot(input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic [CODE_W-1:0] pc);
        @(negedge i_clk);
        start        = 1'b1;
        i_pos_x      = px;
        i_pos_y      = py;
        i_color_code = pc;
        do @(posedge i_clk); while (busy);
        plots_pending.push_back(predict_plot(int'(px), int'(py), int'(pc)));
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
    endtask

    task automatic drain_plots();
        @(negedge i_clk);
        start = 1'b0;
        while (plots_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        plot_result_t exp_res;
        if (i_rst_n && o_done) begin
            if (plots_pending.size() == 0) begin
                $error("result strobe with no plot outstanding");
                fail_count++;
            end else begin
                exp_res = plots_pending.pop_front();
                check_field("byte_addr", int'(exp_res.byte_addr), int'(o_byte_addr));
                check_field("black_byte", int'(exp_res.black_byte), int'(o_black_byte));
                check_field("color_byte", int'(exp_res.color_byte), int'(o_color_byte));
                check_field("written", int'(exp_res.written), int'(o_written));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pwrite))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        send_plot(12'sd0, 12'sd0, COLOR_0);
        send_plot(12'sd199, 12'sd199, COLOR_5);
        send_plot(12'sd0, 12'sd199, COLOR_1);
        send_plot(12'sd199, 12'sd0, COLOR_2);
        // same byte twice in a row
        send_plot(12'sd7, 12'sd8, COLOR_3);
        send_plot(12'sd7, 12'sd9, COLOR_4);
        send_plot(-12'sd1, 12'sd0, COLOR_1);
        send_plot(12'sd0, -12'sd1, COLOR_1);
        send_plot(12'sd200, 12'sd5, COLOR_1);
        send_plot(12'sd5, 12'sd200, COLOR_1);
        send_plot(-12'sd2048, 12'sd2047, COLOR_1);
        send_plot(12'sd2047, -12'sd2048, COLOR_1);
        send_plot(12'sd10, 12'sd10, 3'd6);
        send_plot(12'sd10, 12'sd10, 3'd7);
    endtask

    task automatic test_rotation_mapping();
        logic [ROT_W-1:0] rot;
        drain_plots();
        reg_write(REG_PANEL_WIDTH, 32'd40);
        reg_write(REG_PANEL_HEIGHT, 32'd21);
        for (int r = 1; r < 4; r++) begin
            rot = r[ROT_W-1:0];
            drain_plots();
            reg_write(REG_ROTATION, 32'(rot));
            send_plot(12'sd0, 12'sd0, COLOR_1);
            send_plot(POS_W'(rotated_width() - 1), POS_W'(rotated_height() - 1), COLOR_2);
        end
    endtask

    task automatic test_plane_flags();
        drain_plots();
        reg_write(REG_ROTATION, 32'(ROT_0));
        reg_write(REG_BLACK_INVERTED, 32'd0);
        reg_write(REG_COLOR_INVERTED, 32'd1);
        reg_write(REG_LAYER_MAP, 32'hFFF);
        send_plot(12'sd3, 12'sd3, COLOR_5);
        drain_plots();
        reg_write(REG_LAYER_MAP, 32'd0);
        send_plot(12'sd3, 12'sd4, COLOR_0);
    endtask

    task automatic test_size_limits();
        drain_plots();
        // oversize width saturates; far corner lands past the plane
        reg_write(REG_PANEL_WIDTH, 32'd2047);
        reg_write(REG_PANEL_HEIGHT, 32'd1024);
        send_plot(12'sd1023, 12'sd0, COLOR_0);
        send_plot(12'sd0, 12'sd1023, COLOR_1);
        drain_plots();
        reg_write(REG_PANEL_WIDTH, 32'd0);
        send_plot(12'sd0, 12'sd0, COLOR_2);
        drain_plots();
        reg_write(REG_PANEL_WIDTH, 32'd16);
        reg_write(REG_PANEL_HEIGHT, 32'd16);
        reg_write(REG_UNUSED_6, 32'hFFFF_FFFF);
        reg_write(REG_UNUSED_7, 32'hFFFF_FFFF);
        send_plot(12'sd15, 12'sd15, COLOR_3);
    endtask

    task automatic test_random_plots();
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [CODE_W-1:0]       pc;
        int                      mode;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_plots();
            if (phase == RANDOM_PHASES - 1) begin
                // largest panel that still fits the plane exactly
                reg_write(REG_PANEL_WIDTH, 32'd1024);
                reg_write(REG_PANEL_HEIGHT, 32'd128);
            end else begin
                reg_write(REG_PANEL_WIDTH, $urandom_range(1, 300));
                reg_write(REG_PANEL_HEIGHT, $urandom_range(1, 300));
            end
            reg_write(REG_ROTATION, $urandom_range(0, 3));
            reg_write(REG_BLACK_INVERTED, $urandom_range(0, 1));
            reg_write(REG_COLOR_INVERTED, $urandom_range(0, 1));
            reg_write(REG_LAYER_MAP, $urandom_range(0, 4095));
            case (phase % 3)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 55;
                default: sender_idle_pct = 22;
            endcase
            px = '0;
            py = '0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                mode = $urandom_range(0, 99);
                if (mode < 15) begin
                    px = POS_W'($urandom);
                    py = POS_W'($urandom);
                    pc = CODE_W'($urandom_range(0, 7));
                end else if (mode < 45) begin
                    // stay in the previous byte (rotations 0 and 2) to exercise read-modify-write
                    py = (py & ~POS_W'(7)) + POS_W'($urandom_range(0, 7));
                    pc = CODE_W'($urandom_range(0, 5));
                end else begin
                    px = POS_W'($urandom_range(0, rotated_width() - 1));
                    py = POS_W'($urandom_range(0, rotated_height() - 1));
                    pc = CODE_W'($urandom_range(0, 5));
                end
                send_plot(px, py, pc);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_color_code = '0;
        fail_count   = 0;
        idle_cycles  = 0;
        sender_idle_pct  = 0;
        cfg_panel_width  = 11'd200;
        cfg_panel_height = 11'd200;
        cfg_rotation     = ROT_0;
        cfg_black_inv    = 1'b1;
        cfg_color_inv    = 1'b0;
        cfg_layer_map    = 12'd420;
        foreach (black_img[i]) begin
            black_img[i] = 8'h00;
            color_img[i] = 8'h00;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_rotation_mapping();
        test_plane_flags();
        test_size_limits();
        test_random_plots();

        drain_plots();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && plots_pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
